### rtl/sbpp_pkg.sv
// Shared types and constants for the spectral band peak picker.
package sbpp_pkg;

  localparam int BAND_COUNT  = 6;
  localparam int BAND_W      = 3;
  localparam int BIN_W       = 10;
  localparam int MAG_W       = 32;
  localparam int FRAME_W     = 16;
  localparam int SUM_W       = MAG_W + 3;
  localparam int CFG_INDEX_W = 3;

  localparam logic [BIN_W-1:0] BIN_MAX = '1;

  typedef logic [BAND_COUNT-1:0][BIN_W-1:0] band_edges_t;

  // The highest band's edge sits in the top slice.
  localparam band_edges_t EDGE_RESET = {10'd500, 10'd160, 10'd80, 10'd40, 10'd20, 10'd10};

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             last_bin;
  } bin_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [BAND_W-1:0]  band_number;
    logic [BIN_W-1:0]   peak_bin;
    logic [MAG_W-1:0]   peak_magnitude;
    logic               last_peak;
  } peak_out_t;

  // Per-band results of one finished frame.
  typedef struct packed {
    logic [BAND_COUNT-1:0]            seen;
    logic [BAND_COUNT-1:0][MAG_W-1:0] mag;
    logic [BAND_COUNT-1:0][BIN_W-1:0] bin;
    logic [FRAME_W-1:0]               frame;
  } frame_snap_t;

endpackage

### rtl/sbpp_tracker.sv
// Bin counter, per-band maximum trackers and frame counter.
module sbpp_tracker import sbpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  bin_in_t     bin_in,
  input  band_edges_t edges,
  output logic        frame_done,
  output frame_snap_t snap
);

  logic [BIN_W-1:0]                 bin_counter;
  logic [FRAME_W-1:0]               frame_counter;
  logic [BAND_COUNT-1:0]            seen;
  logic [BAND_COUNT-1:0][MAG_W-1:0] best_mag;
  logic [BAND_COUNT-1:0][BIN_W-1:0] best_bin;

  logic [BAND_COUNT-1:0]            in_band;
  logic [BAND_COUNT-1:0]            take;
  logic [BAND_COUNT-1:0]            seen_next;
  logic [BAND_COUNT-1:0][MAG_W-1:0] best_mag_next;
  logic [BAND_COUNT-1:0][BIN_W-1:0] best_bin_next;

  // Each band checks its own range; bin zero is in no band.
  always_comb begin
    in_band[0] = (bin_counter != '0) && (bin_counter <= edges[0]);
    for (int b = 1; b < BAND_COUNT; b++) begin
      in_band[b] = (bin_counter > edges[b-1]) && (bin_counter <= edges[b]);
    end
    for (int b = 0; b < BAND_COUNT; b++) begin
      // strict compare keeps the earlier bin on a tie
      take[b] = accept && in_band[b] && (!seen[b] || (bin_in.magnitude > best_mag[b]));
      seen_next[b]     = seen[b] | take[b];
      best_mag_next[b] = take[b] ? bin_in.magnitude : best_mag[b];
      best_bin_next[b] = take[b] ? bin_counter : best_bin[b];
    end
  end

  assign frame_done = accept && bin_in.last_bin;
  assign snap.seen  = seen_next;
  assign snap.mag   = best_mag_next;
  assign snap.bin   = best_bin_next;
  assign snap.frame = frame_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter   <= '0;
      frame_counter <= '0;
      seen          <= '0;
      best_mag      <= '0;
      best_bin      <= '0;
    end else if (accept) begin
      if (bin_in.last_bin) begin
        bin_counter   <= '0;
        frame_counter <= frame_counter + 1'b1;
        seen          <= '0;
        best_mag      <= '0;
        best_bin      <= '0;
      end else begin
        if (bin_counter != BIN_MAX) begin
          bin_counter <= bin_counter + 1'b1;
        end
        seen     <= seen_next;
        best_mag <= best_mag_next;
        best_bin <= best_bin_next;
      end
    end
  end

  a_counter_restarts: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> (bin_counter == '0) && (seen == '0))
    else $error("trackers not cleared after frame end");

endmodule

### rtl/sbpp_selector.sv
// Frame snapshot, mean test and serial emission of the peaks.
module sbpp_selector import sbpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_done,
  input  frame_snap_t snap_in,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_stall,
  output peak_out_t   out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_CMP  = 4'b0100,
    S_EMIT = 4'b1000
  } sel_state_t;

  sel_state_t            state;
  frame_snap_t           snap;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      sum_next;
  logic [BAND_COUNT-1:0] mask;
  logic [BAND_COUNT-1:0] mask_next;
  logic [BAND_COUNT-1:0] pick_bit;
  logic [BAND_COUNT-1:0] remain;
  logic [BAND_W-1:0]     pick;
  logic [SUM_W-1:0]      scaled;
  logic                  load_out;
  peak_out_t             out_next;

  always_comb begin
    sum_next = '0;
    for (int b = 0; b < BAND_COUNT; b++) begin
      sum_next = sum_next + (snap.seen[b] ? SUM_W'(snap.mag[b]) : '0);
    end
  end

  // 6*max >= sum, as (max<<2) + (max<<1)
  always_comb begin
    mask_next = '0;
    scaled    = '0;
    for (int b = 0; b < BAND_COUNT; b++) begin
      scaled = (SUM_W'(snap.mag[b]) << 2) + (SUM_W'(snap.mag[b]) << 1);
      mask_next[b] = snap.seen[b] && (scaled >= sum);
    end
  end

  // lowest pending band goes first
  always_comb begin
    pick = '0;
    for (int b = BAND_COUNT - 1; b >= 0; b--) begin
      if (mask[b]) begin
        pick = BAND_W'(b);
      end
    end
  end

  assign pick_bit = mask & (~mask + BAND_COUNT'(1));
  assign remain   = mask & ~pick_bit;
  assign busy     = (state != S_IDLE);
  assign load_out = (state == S_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    out_next.frame_number   = snap.frame;
    out_next.band_number    = pick;
    out_next.peak_bin       = snap.bin[pick];
    out_next.peak_magnitude = snap.mag[pick];
    out_next.last_peak      = (remain == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mask  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (frame_done) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_CMP;
        end
        S_CMP: begin
          mask  <= mask_next;
          state <= (mask_next == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (load_out) begin
            mask <= remain;
            if (remain == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && frame_done) begin
      snap <= snap_in;
    end
    if (state == S_SUM) begin
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (mask != '0))
    else $error("emit state with no pending band");

  a_frame_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> (state == S_IDLE))
    else $error("frame end arrived while previous frame pending");

  a_last_peak_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (load_out && out_next.last_peak) |=> (state == S_IDLE))
    else $error("last peak sent but emission continues");

endmodule

### rtl/spectral_band_peak_picker.sv
// Top level of the spectral band peak picker: band edge registers and the two stages.
// Throughput: one bin request per cycle. A last-bin request waits while the selector
//   is still busy with the previous frame: summing, comparing and emitting its peaks.
// Output: after the last-bin request the selector snapshots the maxima, sums them and
//   tests each band, then registers one peak per cycle as the output side takes them.
// Reset (rst, synchronous, high) restores default edges and clears counters and trackers.
module spectral_band_peak_picker import sbpp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bin_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output peak_out_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BIN_W-1:0]       cfg_data
);

  band_edges_t edges;
  logic        accept;
  logic        frame_done;
  logic        busy;
  frame_snap_t snap;

  // Hold only the last bin of a frame while the snapshot bank is in use;
  // ordinary bins keep flowing into the trackers.
  assign in_stall = in_data.last_bin && busy;
  assign accept   = in_valid && !in_stall;

  // Drop writes to indexes beyond the band list.
  always_ff @(posedge clk) begin
    if (rst) begin
      edges <= EDGE_RESET;
    end else if (cfg_write && (cfg_index < CFG_INDEX_W'(BAND_COUNT))) begin
      edges[cfg_index] <= cfg_data;
    end
  end

  // Advance the per-band maxima on every accepted bin.
  sbpp_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .bin_in     (in_data),
    .edges      (edges),
    .frame_done (frame_done),
    .snap       (snap)
  );

  // Sum the maxima, test each against the mean, emit survivors in band order.
  sbpp_selector u_selector (
    .clk        (clk),
    .rst        (rst),
    .frame_done (frame_done),
    .snap_in    (snap),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### verif/spectral_band_peak_picker_test.sv
// Self-checking testbench for the spectral band peak picker with a built-in band tracker.
module spectral_band_peak_picker_test;
  import sbpp_pkg::*;

  localparam int PHASE_ITEMS  = 20;   // random bins per edge setting
  localparam int SETTLE       = 20;   // quiet cycles before a register write or the end
  localparam int HOLD_AT      = 14;   // accepted bins before the long output hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_MAX   = 10;
  localparam int CFG_SPARE_LO = BAND_COUNT;     // register indexes past the list
  localparam int CFG_SPARE_HI = BAND_COUNT + 1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  bin_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  peak_out_t              out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [BIN_W-1:0]       cfg_data = '0;

  spectral_band_peak_picker u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Band tracker state, mirrored from the block's behavior.
  logic [BIN_W-1:0]   band_edge_cfg [BAND_COUNT];
  logic [BIN_W-1:0]   bin_idx;
  logic [MAG_W-1:0]   best_mag [BAND_COUNT];
  logic [BIN_W-1:0]   best_bin [BAND_COUNT];
  logic               band_hit [BAND_COUNT];
  logic [FRAME_W-1:0] frame_cnt;

  bin_in_t   bins_to_send [$];
  peak_out_t peaks_due [$];

  int n_accepted = 0;
  int n_errors = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [MAG_W-1:0] rand_mag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 70) return $urandom_range(0, 7);           // small values make ties likely
    if (r < 85) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return $urandom >> $urandom_range(1, 31);
  endfunction

  task automatic clear_bands();
    for (int b = 0; b < BAND_COUNT; b++) begin
      best_mag[b] = '0;
      best_bin[b] = '0;
      band_hit[b] = 1'b0;
    end
    bin_idx = '0;
  endtask

  // Take one accepted bin into the tracker; at the frame end queue its peaks.
  task automatic track_bin(input bin_in_t item);
    logic [BIN_W:0] lo;
    logic [63:0]    total;
    peak_out_t      batch [BAND_COUNT];
    int             n_pk;
    total = '0;
    n_pk = 0;
    for (int b = 0; b < BAND_COUNT; b++) begin
      // Widen the start so an edge of 1023 leaves the next band empty.
      lo = (b == 0) ? (BIN_W+1)'(1) : {1'b0, band_edge_cfg[b-1]} + (BIN_W+1)'(1);
      if ({1'b0, bin_idx} >= lo && bin_idx <= band_edge_cfg[b]) begin
        if (!band_hit[b] || item.magnitude > best_mag[b]) begin
          best_mag[b] = item.magnitude;
          best_bin[b] = bin_idx;
          band_hit[b] = 1'b1;
        end
      end
    end
    if (!item.last_bin) begin
      if (bin_idx != BIN_MAX) bin_idx = bin_idx + 1'b1;
    end else begin
      for (int b = 0; b < BAND_COUNT; b++)
        if (band_hit[b]) total += {32'd0, best_mag[b]};
      for (int b = 0; b < BAND_COUNT; b++) begin
        if (band_hit[b] && {32'd0, best_mag[b]} * 64'd6 >= total) begin
          batch[n_pk].frame_number   = frame_cnt;
          batch[n_pk].band_number    = BAND_W'(b);
          batch[n_pk].peak_bin       = best_bin[b];
          batch[n_pk].peak_magnitude = best_mag[b];
          batch[n_pk].last_peak      = 1'b0;
          n_pk++;
        end
      end
      if (n_pk > 0) batch[n_pk-1].last_peak = 1'b1;
      for (int k = 0; k < n_pk; k++) peaks_due = {peaks_due, batch[k]};
      clear_bands();
      frame_cnt = frame_cnt + 1'b1;
    end
  endtask

  // Sender: present queued bins with random gaps and occasional gap-free runs.
  int in_gap = 0;
  int in_calm = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      n_accepted <= 0;
      in_gap = 0;
      in_calm = 0;
    end else begin
      if (in_valid && !in_stall) begin
        track_bin(in_data);
        n_accepted <= n_accepted + 1;
      end
      // Hold a stalled request; otherwise advance to a gap or the next bin.
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (bins_to_send.size() != 0) begin
          in_data  <= bins_to_send.pop_front();
          in_valid <= 1'b1;
          if (in_calm > 0) begin
            in_calm--;
          end else begin
            in_gap = pick_gap();
            if ($urandom_range(0, 15) == 0) in_calm = $urandom_range(16, 48);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off once, so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each peak request against the oldest prediction.
  peak_out_t want;
  int out_gap = 0;
  int out_calm = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap = 0;
      out_calm = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (peaks_due.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display("unexpected peak: frame %0d band %0d bin %0d mag %h last %0b",
                     out_data.frame_number, out_data.band_number, out_data.peak_bin,
                     out_data.peak_magnitude, out_data.last_peak);
        end else begin
          want = peaks_due.pop_front();
          if (out_data.frame_number !== want.frame_number ||
              out_data.band_number !== want.band_number ||
              out_data.peak_bin !== want.peak_bin ||
              out_data.peak_magnitude !== want.peak_magnitude ||
              out_data.last_peak !== want.last_peak) begin
            n_errors++;
            if (n_errors <= REPORT_MAX) begin
              $display("peak mismatch: expected frame %0d band %0d bin %0d mag %h last %0b",
                       want.frame_number, want.band_number, want.peak_bin,
                       want.peak_magnitude, want.last_peak);
              $display("               got      frame %0d band %0d bin %0d mag %h last %0b",
                       out_data.frame_number, out_data.band_number, out_data.peak_bin,
                       out_data.peak_magnitude, out_data.last_peak);
            end
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_calm > 0) begin
          out_calm--;
        end else begin
          out_gap = pick_gap();
          if ($urandom_range(0, 15) == 0) out_calm = $urandom_range(16, 48);
        end
      end
    end
  end

  task automatic push_bin(input logic [MAG_W-1:0] mag, input logic last);
    bin_in_t item;
    item.magnitude = mag;
    item.last_bin  = last;
    bins_to_send = {bins_to_send, item};
  endtask

  task automatic write_edge(input int idx, input logic [BIN_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_INDEX_W'(idx);
    cfg_data  <= value;
    if (idx < BAND_COUNT) band_edge_cfg[idx] = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every bin is taken and every peak has come, then let the block settle.
  task automatic drain();
    do @(negedge clk);
    while (bins_to_send.size() != 0 || in_valid || peaks_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Random frames of random length over the current edges.
  task automatic random_frames(input int n_items);
    int span;
    int len;
    int sent;
    span = 1;
    for (int b = 0; b < BAND_COUNT; b++)
      if (int'(band_edge_cfg[b]) > span) span = int'(band_edge_cfg[b]);
    if (span > 37) span = 37;
    span += 3;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, span);
      if (len > n_items - sent) len = n_items - sent;
      for (int i = 0; i < len; i++) push_bin(rand_mag(), i == len - 1);
      sent += len;
    end
  endtask

  logic [BIN_W-1:0] e;

  initial begin
    for (int b = 0; b < BAND_COUNT; b++) band_edge_cfg[b] = EDGE_RESET[b];
    clear_bands();
    frame_cnt = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default edges: bin zero ignored, tie in band 0 kept at the earlier bin,
    // weak band 1 falls below the mean.
    push_bin('1, 1'b0);
    for (int i = 1; i <= 10; i++)
      push_bin((i == 3 || i == 7) ? 32'h0000_0100 : 32'(i), 1'b0);
    push_bin(32'h0000_0010, 1'b1);
    drain();

    // Narrowest bands, one bin each; spare indexes must not disturb them.
    for (int b = 0; b < BAND_COUNT; b++) write_edge(b, BIN_W'(b + 1));
    write_edge(CFG_SPARE_LO, '1);
    write_edge(CFG_SPARE_HI, '0);
    @(negedge clk);
    for (int i = 0; i < 7; i++) push_bin('1, i == 6);        // sum overflows 32 bits
    for (int i = 0; i < 8; i++) push_bin((i == 7) ? '1 : '0, i == 7); // bin past the last edge
    push_bin(32'h1234_5678, 1'b1);                           // frame where no band saw a bin
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0, 3: begin
          e = BIN_W'($urandom_range(1, 4));
          for (int b = 0; b < BAND_COUNT; b++) begin
            write_edge(b, (p == 3 && b == BAND_COUNT - 1) ? '1 : e);
            e = e + BIN_W'($urandom_range(1, 5));
          end
        end
        1, 4: begin
          // Edges out of order: bands overlap or stay empty.
          for (int b = 0; b < BAND_COUNT; b++)
            write_edge(b, BIN_W'($urandom_range(1, (p == 1) ? 40 : 24)));
        end
        default: begin
          for (int b = 0; b < BAND_COUNT; b++) write_edge(b, '1);
        end
      endcase
      @(negedge clk);
      random_frames(PHASE_ITEMS);
      drain();
    end

    if (n_errors == 0) begin
      $display("spectral_band_peak_picker_test passed");
    end else begin
      $display("spectral_band_peak_picker_test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("spectral_band_peak_picker_test failed");
    $finish;
  end

endmodule

### spectral_band_peak_picker.f
rtl/sbpp_pkg.sv
rtl/sbpp_tracker.sv
rtl/sbpp_selector.sv
rtl/spectral_band_peak_picker.sv
verif/spectral_band_peak_picker_test.sv
